### design/pcrrs_pkg.sv
// Package: verdict codes, header offsets and protocol constants for the frame classifier.
`default_nettype none
package pcrrs_pkg;

	typedef enum logic [1:0] {
		VERDICT_DROP     = 2'd0,
		VERDICT_PASS     = 2'd1,
		VERDICT_REDIRECT = 2'd2
	} verdict_t;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// byte offsets within the frame
	localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
	localparam logic [15:0] POS_VER_IHL    = 16'd14;
	localparam logic [15:0] POS_TOTLEN_HI  = 16'd16;
	localparam logic [15:0] POS_TOTLEN_LO  = 16'd17;
	localparam logic [15:0] POS_V6_NEXTHDR = 16'd20;
	localparam logic [15:0] POS_V4_PROTO   = 16'd23;

	// minimum frame lengths
	localparam logic [15:0] LEN_ETH_HDR    = 16'd14;
	localparam logic [15:0] LEN_IPV4_MIN   = 16'd34;
	localparam logic [15:0] LEN_IPV6_MIN   = 16'd54;
	localparam logic [15:0] POS_SATURATED  = 16'hFFFF;

	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam int          MAX_SOCKETS    = 64;
	localparam int          QIDX_W         = 6;
	localparam int          SCNT_W         = 7;

endpackage
`default_nettype wire

### design/packet_classify_round_robin_steer_unit.sv
// Top level: Ethernet/IP frame classifier with round-robin socket steering.
//
//  channel   dir   handshake                fields (lsb first)
//  s_*       in    s_tvalid/s_tready        tdata: data_byte[7:0]; tlast: last_byte
//  m_*       out   m_tvalid/m_tready        tdata: verdict[1:0], queue_index[7:2]
//  cfg_*     in    cfg_wr_en                cfg_wr_data: socket_count[6:0]
//
// One byte is taken every cycle while s_tready is high. Each byte is held in the
// input register, where field capture and classification run; the verdict of the
// last byte lands in the output register.
// Reset clears all frame state, the socket index and sets socket_count to 1.
// While a verdict waits on m_tready, a further last byte is held in the input
// register; ordinary bytes keep flowing.
`default_nettype none
module packet_classify_round_robin_steer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [1:0] verdict, [7:2] queue_index
	input  wire logic       cfg_wr_en,
	input  wire logic [6:0] cfg_wr_data // socket_count
);

	localparam int QW = pcrrs_pkg::QIDX_W;

	// configuration
	logic [pcrrs_pkg::SCNT_W-1:0] socket_count_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-frame state
	logic [15:0] pos_q;
	logic [15:0] ether_type_q;
	logic [3:0]  ip_version_q;
	logic [5:0]  ihl_bytes_q;
	logic [15:0] total_len_q;
	logic [7:0]  proto_q;
	logic [QW-1:0] rr_q;

	// output register
	logic                  out_valid_q;
	pcrrs_pkg::verdict_t   out_verdict_q;
	logic [QW-1:0]         out_qidx_q;

	logic s1_go;
	logic s1_fire;
	logic s1_done;

	// next-state values with this byte captured
	logic [15:0] et_n;
	logic [3:0]  ver_n;
	logic [5:0]  ihl_n;
	logic [15:0] tlen_n;
	logic [7:0]  proto_n;
	logic [15:0] len;
	logic [15:0] l3;
	pcrrs_pkg::verdict_t verdict;
	logic [QW-1:0] mask;
	logic [QW-1:0] rr_inc;
	logic [QW-1:0] rr_next;

	// handshake: a last byte needs a free output slot
	assign s1_go    = !last_s1 || !out_valid_q || m_tready;
	assign s1_fire  = valid_s1 && s1_go;
	assign s1_done  = s1_fire && last_s1;
	assign s_tready = !valid_s1 || s1_go;

	// field capture
	always_comb begin
		et_n    = ether_type_q;
		ver_n   = ip_version_q;
		ihl_n   = ihl_bytes_q;
		tlen_n  = total_len_q;
		proto_n = proto_q;
		if (pos_q == pcrrs_pkg::POS_ETYPE_HI) begin
			et_n[15:8] = byte_s1;
		end
		if (pos_q == pcrrs_pkg::POS_ETYPE_LO) begin
			et_n[7:0] = byte_s1;
		end
		if (pos_q == pcrrs_pkg::POS_VER_IHL) begin
			ver_n = byte_s1[7:4];
			ihl_n = {byte_s1[3:0], 2'b00};
		end
		if (pos_q == pcrrs_pkg::POS_TOTLEN_HI) begin
			tlen_n[15:8] = byte_s1;
		end
		if (pos_q == pcrrs_pkg::POS_TOTLEN_LO) begin
			tlen_n[7:0] = byte_s1;
		end
		if (pos_q == pcrrs_pkg::POS_V4_PROTO && et_n == pcrrs_pkg::ETHERTYPE_IPV4) begin
			proto_n = byte_s1;
		end
		if (pos_q == pcrrs_pkg::POS_V6_NEXTHDR && et_n == pcrrs_pkg::ETHERTYPE_IPV6) begin
			proto_n = byte_s1;
		end
	end

	// frame length, held once the count saturates
	assign len = (pos_q == pcrrs_pkg::POS_SATURATED) ? pcrrs_pkg::POS_SATURATED
	                                                 : pos_q + 16'd1;
	assign l3  = len - pcrrs_pkg::LEN_ETH_HDR;

	// classification
	always_comb begin
		verdict = pcrrs_pkg::VERDICT_REDIRECT;
		if (len < pcrrs_pkg::LEN_ETH_HDR) begin
			verdict = pcrrs_pkg::VERDICT_DROP;
		end else if (et_n == pcrrs_pkg::ETHERTYPE_IPV4) begin
			if (len < pcrrs_pkg::LEN_IPV4_MIN || ver_n != pcrrs_pkg::IP_VERSION_4 ||
			    l3 != tlen_n || l3 < {10'd0, ihl_n}) begin
				verdict = pcrrs_pkg::VERDICT_DROP;
			end else if (proto_n != pcrrs_pkg::PROTO_TCP && proto_n != pcrrs_pkg::PROTO_UDP) begin
				verdict = pcrrs_pkg::VERDICT_PASS;
			end
		end else if (et_n == pcrrs_pkg::ETHERTYPE_IPV6) begin
			if (len < pcrrs_pkg::LEN_IPV6_MIN) begin
				verdict = pcrrs_pkg::VERDICT_DROP;
			end else if (proto_n != pcrrs_pkg::PROTO_TCP && proto_n != pcrrs_pkg::PROTO_UDP) begin
				verdict = pcrrs_pkg::VERDICT_PASS;
			end
		end else begin
			verdict = pcrrs_pkg::VERDICT_PASS;
		end
	end

	// round-robin step, socket_count - 1 used as a raw mask
	assign mask   = QW'(socket_count_q - 7'd1);
	assign rr_inc = (rr_q + QW'(1)) & mask;
	assign rr_next = ({5'd0, rr_inc} >= 11'(pcrrs_pkg::MAX_SOCKETS)) ? '0 : rr_inc;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			socket_count_q <= 7'd1;
		end else if (cfg_wr_en) begin
			socket_count_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// frame state: cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			ether_type_q <= '0;
			ip_version_q <= '0;
			ihl_bytes_q  <= '0;
			total_len_q  <= '0;
			proto_q      <= '0;
		end else if (s1_done) begin
			pos_q        <= '0;
			ether_type_q <= '0;
			ip_version_q <= '0;
			ihl_bytes_q  <= '0;
			total_len_q  <= '0;
			proto_q      <= '0;
		end else if (s1_fire) begin
			if (pos_q != pcrrs_pkg::POS_SATURATED) begin
				pos_q <= pos_q + 16'd1;
			end
			ether_type_q <= et_n;
			ip_version_q <= ver_n;
			ihl_bytes_q  <= ihl_n;
			total_len_q  <= tlen_n;
			proto_q      <= proto_n;
		end
	end

	// socket index, kept across frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= '0;
		end else if (s1_done && verdict == pcrrs_pkg::VERDICT_REDIRECT) begin
			rr_q <= rr_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			out_verdict_q <= verdict;
			out_qidx_q    <= (verdict == pcrrs_pkg::VERDICT_REDIRECT) ? rr_next : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_qidx_q, out_verdict_q};

	// checks
	a_no_bad_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'b11))
		else $error("illegal verdict code");

	a_idx_zero_unless_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != pcrrs_pkg::VERDICT_REDIRECT) |-> (m_tdata[7:2] == '0))
		else $error("queue index set without redirect");

	a_pos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |=> (pos_q == '0 && ether_type_q == '0))
		else $error("frame state not cleared after last byte");

	a_rr_only_on_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_done && verdict == pcrrs_pkg::VERDICT_REDIRECT) |=> $stable(rr_q))
		else $error("socket index moved without redirect");

endmodule
`default_nettype wire
